// File: sv/sdfd_pkg.sv
// ----------------------------------------------------------------------------
// sdfd_pkg: shared types and constants for the serial display frame deframer
// Holds the header codes, the command format between front and back ends,
// and the hunt state encoding.
// ----------------------------------------------------------------------------
package sdfd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h5A;
  localparam logic [7:0] HDR_SECOND = 8'hA5;
  localparam logic [8:0] HDR_BYTES  = 9'd3;

  localparam logic [8:0] MAX_FRAME_RESET = 9'd258;

  // Input action codes.
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Result kind codes.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERR   = 1'b1;

  // Register index of max_frame_bytes.
  localparam logic REG_MAX_FRAME = 1'b0;

  typedef enum logic [1:0] {
    PH_WAIT_FIRST  = 2'd0,
    PH_WAIT_SECOND = 2'd1,
    PH_WAIT_LEN    = 2'd2,
    PH_BODY        = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BODY   = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_ERROR  = 2'd2
  } cmd_kind_t;

  // One command from the front end. For a header command, data holds the
  // length byte and last is set when the length is zero.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // Status of the command queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// File: sv/sdfd_front.sv
// ----------------------------------------------------------------------------
// sdfd_front: header hunt and byte classification
// Tracks the hunt phase and the body count, and turns each accepted byte
// into at most one command for the back end.
// ----------------------------------------------------------------------------
module sdfd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            action,
  input  logic [7:0]      rx_byte,
  input  logic [8:0]      max_frame_bytes,
  output logic            cmd_push,
  output sdfd_pkg::cmd_t  cmd,
  output sdfd_pkg::phase_t phase
);
  import sdfd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] left_r, left_nxt;
  logic       too_long;
  logic       body_end;

  assign too_long = ({1'b0, rx_byte} + HDR_BYTES) > max_frame_bytes;
  assign body_end = (left_r <= 8'd1);
  assign phase    = phase_r;

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    if (action == ACT_FLUSH) begin
      phase_nxt = PH_WAIT_FIRST;
      left_nxt  = 8'd0;
    end else begin
      case (phase_r)
        PH_WAIT_FIRST: begin
          if (rx_byte == HDR_FIRST) phase_nxt = PH_WAIT_SECOND;
        end
        PH_WAIT_SECOND: begin
          if (rx_byte == HDR_SECOND) phase_nxt = PH_WAIT_LEN;
          else if (rx_byte == HDR_FIRST) phase_nxt = PH_WAIT_SECOND;
          else phase_nxt = PH_WAIT_FIRST;
        end
        PH_WAIT_LEN: begin
          if (too_long) begin
            phase_nxt = (rx_byte == HDR_FIRST) ? PH_WAIT_SECOND : PH_WAIT_FIRST;
            left_nxt  = 8'd0;
          end else if (rx_byte == 8'd0) begin
            phase_nxt = PH_WAIT_FIRST;
            left_nxt  = 8'd0;
          end else begin
            phase_nxt = PH_BODY;
            left_nxt  = rx_byte;
          end
        end
        PH_BODY: begin
          if (body_end) begin
            phase_nxt = PH_WAIT_FIRST;
            left_nxt  = 8'd0;
          end else begin
            left_nxt = left_r - 8'd1;
          end
        end
        default: begin
          phase_nxt = PH_WAIT_FIRST;
          left_nxt  = 8'd0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_push  = 1'b0;
    cmd.kind  = CMD_BODY;
    cmd.data  = rx_byte;
    cmd.last  = 1'b0;
    if (action == ACT_BYTE) begin
      case (phase_r)
        PH_WAIT_LEN: begin
          cmd_push = accept;
          if (too_long) begin
            cmd.kind = CMD_ERROR;
            cmd.data = 8'd0;
            cmd.last = 1'b1;
          end else begin
            cmd.kind = CMD_HEADER;
            cmd.last = (rx_byte == 8'd0);
          end
        end
        PH_BODY: begin
          cmd_push = accept;
          cmd.last = body_end;
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_FIRST;
      left_r  <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// File: sv/sdfd_cmd_q.sv
// ----------------------------------------------------------------------------
// sdfd_cmd_q: short command queue between front and back ends
// A small circular buffer of commands with a fill count.
// ----------------------------------------------------------------------------
module sdfd_cmd_q #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sdfd_pkg::cmd_t    din,
  input  logic              pop,
  output sdfd_pkg::cmd_t    dout,
  output sdfd_pkg::q_stat_t stat
);
  import sdfd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          ent_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign dout       = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// File: sv/sdfd_back.sv
// ----------------------------------------------------------------------------
// sdfd_back: result generation
// Expands header commands into three results and passes other commands
// through as one result, into a registered output stage.
// ----------------------------------------------------------------------------
module sdfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sdfd_pkg::cmd_t    head,
  input  sdfd_pkg::q_stat_t q_stat,
  output logic              q_pop,
  input  logic              out_take,
  output logic              out_valid,
  output logic              out_kind,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import sdfd_pkg::*;

  logic [1:0] step_r, step_nxt;
  logic       valid_r;
  logic       kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       head_done;

  assign load  = q_stat.valid && (!valid_r || out_take);
  assign q_pop = load && head_done;

  always_comb begin
    kind_nxt  = KIND_FRAME;
    byte_nxt  = head.data;
    last_nxt  = head.last;
    head_done = 1'b1;
    case (head.kind)
      CMD_HEADER: begin
        case (step_r)
          2'd0: begin
            byte_nxt  = HDR_FIRST;
            last_nxt  = 1'b0;
            head_done = 1'b0;
          end
          2'd1: begin
            byte_nxt  = HDR_SECOND;
            last_nxt  = 1'b0;
            head_done = 1'b0;
          end
          default: begin
            head_done = 1'b1;
          end
        endcase
      end
      CMD_ERROR: begin
        kind_nxt = KIND_ERR;
        byte_nxt = 8'd0;
        last_nxt = 1'b1;
      end
      default: begin
        kind_nxt = KIND_FRAME;
      end
    endcase
    step_nxt = head_done ? 2'd0 : step_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        step_r  <= step_nxt;
      end else if (out_take) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

// File: sv/serial_display_frame_deframer.sv
// ----------------------------------------------------------------------------
// serial_display_frame_deframer: header/length frame deframer
// Hunts for 0x5A 0xA5, reads a length byte and forwards the whole frame, or an error if it is too long.
// ----------------------------------------------------------------------------
// The block takes one received byte (or a flush request) per cycle whenever
// full is low; full rises only when the command queue between the front and
// back ends holds CMD_DEPTH commands. The front end classifies each byte in
// the cycle it is accepted. A length byte of an accepted frame becomes a
// header command that the back end expands into three results (0x5A, 0xA5
// and the length), one per cycle while popped; every body byte and every
// too-long error becomes one result. Results leave through a registered
// output stage at up to one per cycle, so a frame of L body bytes yields
// L+3 results and the input side runs at one byte per cycle while results
// are popped. A frame whose total length exceeds max_frame_bytes yields a
// single error result marked last. Flush clears the hunt state but does
// not drop results already queued. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module serial_display_frame_deframer #(
  parameter int CMD_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        push,
  output logic        full,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  // Result channel.
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [7:0]  out_frame_byte,
  output logic        out_last,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sdfd_pkg::*;

  logic       in_acc;
  logic       cmd_push;
  cmd_t       cmd;
  cmd_t       q_head;
  q_stat_t    q_stat;
  logic       q_pop;
  logic       out_valid;
  phase_t     front_phase;
  logic [8:0] max_frame_r;
  logic       cfg_wr;

  // The register index is paddr divided by four.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_FRAME);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RESET;
    end else if (cfg_wr) begin
      max_frame_r <= pwdata[8:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_FRAME) ? {23'd0, max_frame_r} : 32'd0;

  // An item is taken whenever the queue has room, even if the output stalls.
  assign full   = q_stat.full;
  assign in_acc = push && !full;

  sdfd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_acc),
    .action          (in_action),
    .rx_byte         (in_rx_byte),
    .max_frame_bytes (max_frame_r),
    .cmd_push        (cmd_push),
    .cmd             (cmd),
    .phase           (front_phase)
  );

  sdfd_cmd_q #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd),
    .pop   (q_pop),
    .dout  (q_head),
    .stat  (q_stat)
  );

  sdfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_take  (pop && !empty),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .out_byte  (out_frame_byte),
    .out_last  (out_last)
  );

  assign empty = !out_valid;

  // A flush always sends the hunt back to the first header byte.
  a_flush_resets_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_action == ACT_FLUSH) |=> (front_phase == PH_WAIT_FIRST))
    else $error("hunt phase not cleared by flush");

  // Error results are always single, last and carry a zero byte.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_ERR) |-> (out_last && out_frame_byte == 8'd0))
    else $error("malformed error result");

  // The front end never pushes a command into a full queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !cmd_push)
    else $error("command pushed into full queue");

  // No command reaches the queue while hunting for a header.
  a_hunt_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (front_phase == PH_WAIT_FIRST || front_phase == PH_WAIT_SECOND) |-> !cmd_push)
    else $error("command produced during header hunt");

endmodule
